FILE: sv/rarst_pkg.sv
// shared types and constants for the range-add / range-sum segment tree
`timescale 1ns / 1ps
`default_nettype none

package rarst_pkg;

  // field widths
  localparam int POS_W       = 11;
  localparam int DATA_W      = 32;
  // node index width: an 11-bit position range never needs a node index above 2^13
  localparam int NODE_W      = 13;
  // depth of the walk work list
  localparam int STACK_DEPTH = 24;

  // opcodes
  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // leaf count after reset
  localparam logic [POS_W-1:0] LEAF_COUNT_RST = 11'd1024;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_EXEC,
    ST_ACC
  } state_t;

  typedef struct packed {
    logic                     opcode;
    logic [POS_W-1:0]         range_low;
    logic [POS_W-1:0]         range_high;
    logic signed [DATA_W-1:0] add_amount;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] range_sum;
    logic                     bad_range;
  } out_item_t;

  // one node still to visit in a range walk
  typedef struct packed {
    logic [NODE_W-1:0] node;
    logic [POS_W-1:0]  lo_cov;
    logic [POS_W-1:0]  hi_cov;
    logic [POS_W-1:0]  lo_req;
    logic [POS_W-1:0]  hi_req;
    logic [DATA_W-1:0] carry;
  } walk_t;

endpackage

`default_nettype wire

FILE: sv/rarst_ram.sv
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module rarst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: sv/range_add_range_sum_tree.sv
// top level: segment tree with range add and range sum over two node memories
`timescale 1ns / 1ps
`default_nettype none

// Range-add / range-sum segment tree. Raise start with an item on cmd while
// busy is low; the item is taken at that edge. Exactly one result follows on
// result, marked by a one-cycle done strobe, and it cannot be held off. A bad
// range answers on the next cycle. A good item walks the tree node by node:
// each visited node takes a read of the sum and pending-add memories and then
// an update and step, and a fully covered node in a query one more step for
// its accumulate. A range visits up to about four nodes per tree level.
// After reset both memories are swept to zero, one entry per cycle, with busy
// high; leaf_count may be written during that time.

module range_add_range_sum_tree
  import rarst_pkg::*;
#(
  parameter int TREE_NODES = 4096,
  parameter int MAX_LEAVES = 1024
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  output logic                  busy,
  input  wire in_item_t         cmd,
  output logic                  done,
  output out_item_t             result,
  input  wire logic             cfg_we,
  input  wire logic [POS_W-1:0] cfg_wdata
);

  localparam int AW     = $clog2(TREE_NODES);
  localparam int SP_W   = $clog2(STACK_DEPTH + 1);
  localparam int STK_AW = $clog2(STACK_DEPTH);

  state_t            state, state_next;
  logic [AW-1:0]     clr_addr, clr_addr_next;
  logic [POS_W-1:0]  leaf_count;
  walk_t             cur, cur_next;
  walk_t             stack [STACK_DEPTH];
  logic [SP_W-1:0]   sp, sp_next;
  logic              op, op_next;
  logic [DATA_W-1:0] amt, amt_next;
  logic [DATA_W-1:0] total, total_next;
  logic [DATA_W-1:0] prod, prod_next;
  logic              node_ok, node_ok_next;
  logic [DATA_W-1:0] sum_q, sum_q_next;
  logic [DATA_W-1:0] carry_q, carry_q_next;
  logic              done_next;
  out_item_t         result_next;

  // memory ports
  logic              sum_we, pend_we;
  logic [AW-1:0]     wr_addr, rd_addr;
  logic [DATA_W-1:0] sum_wdata, pend_wdata;
  logic [DATA_W-1:0] sum_rdata, pend_rdata;

  // walk helpers
  logic [POS_W-1:0]  n_leaves;
  logic              bad;
  logic [DATA_W-1:0] sum_rd, pend_rd, carry_new, ch_carry;
  logic              exact;
  logic [POS_W:0]    mid_sum;
  logic [POS_W-1:0]  mid, mid_p1, overlap, span;
  logic [NODE_W-1:0] left_node, right_node;
  logic [SP_W-1:0]   sp_m1;
  logic              push_en;
  walk_t             push_entry;

  assign busy = (state != ST_IDLE);

  // effective leaf count, saturated to the tree size
  assign n_leaves = (32'(leaf_count) > 32'(MAX_LEAVES)) ? POS_W'(MAX_LEAVES) : leaf_count;

  // range check on the incoming item
  assign bad = (cmd.range_low == '0) || (cmd.range_high < cmd.range_low) ||
               (cmd.range_high > n_leaves);

  // node data, zero for nodes beyond the memory
  assign sum_rd    = node_ok ? sum_rdata  : '0;
  assign pend_rd   = node_ok ? pend_rdata : '0;
  assign carry_new = cur.carry + pend_rd;
  assign ch_carry  = (op == OP_QUERY) ? carry_new : '0;

  // split point and children of the current node
  assign exact      = (cur.lo_req == cur.lo_cov) && (cur.hi_req == cur.hi_cov);
  assign mid_sum    = {1'b0, cur.lo_cov} + {1'b0, cur.hi_cov};
  assign mid        = mid_sum[POS_W:1];
  assign mid_p1     = mid + POS_W'(1);
  assign left_node  = {cur.node[NODE_W-2:0], 1'b0};
  assign right_node = {cur.node[NODE_W-2:0], 1'b1};
  assign overlap    = cur.hi_req - cur.lo_req + POS_W'(1);
  assign span       = cur.hi_cov - cur.lo_cov + POS_W'(1);
  assign sp_m1      = sp - SP_W'(1);

  assign rd_addr = AW'(cur.node);

  // next state, memory controls and datapath
  always_comb begin
    state_next    = state;
    clr_addr_next = clr_addr;
    cur_next      = cur;
    sp_next       = sp;
    op_next       = op;
    amt_next      = amt;
    total_next    = total;
    prod_next     = prod;
    node_ok_next  = node_ok;
    sum_q_next    = sum_q;
    carry_q_next  = carry_q;
    done_next     = 1'b0;
    result_next   = result;
    push_en       = 1'b0;
    push_entry    = cur;
    sum_we        = 1'b0;
    pend_we       = 1'b0;
    wr_addr       = AW'(cur.node);
    sum_wdata     = sum_rd + prod;
    pend_wdata    = pend_rd + amt;

    unique case (state)
      ST_CLEAR: begin
        sum_we     = 1'b1;
        pend_we    = 1'b1;
        wr_addr    = clr_addr;
        sum_wdata  = '0;
        pend_wdata = '0;
        if (clr_addr == AW'(TREE_NODES - 1)) begin
          state_next = ST_IDLE;
        end else begin
          clr_addr_next = clr_addr + AW'(1);
        end
      end

      ST_IDLE: begin
        if (start) begin
          if (bad) begin
            done_next             = 1'b1;
            result_next.range_sum = '0;
            result_next.bad_range = 1'b1;
          end else begin
            cur_next   = '{node: NODE_W'(1), lo_cov: POS_W'(1), hi_cov: n_leaves,
                           lo_req: cmd.range_low, hi_req: cmd.range_high, carry: '0};
            sp_next    = '0;
            op_next    = cmd.opcode;
            amt_next   = cmd.add_amount;
            total_next = '0;
            state_next = ST_READ;
          end
        end
      end

      ST_READ: begin
        node_ok_next = (32'(cur.node) < 32'(TREE_NODES));
        prod_next    = amt * 32'(overlap);
        state_next   = ST_EXEC;
      end

      ST_EXEC: begin
        if (exact) begin
          if (op == OP_ADD) begin
            pend_we = node_ok;
          end else begin
            sum_q_next   = sum_rd;
            carry_q_next = carry_new;
          end
        end else begin
          sum_we     = node_ok && (op == OP_ADD);
          state_next = ST_READ;
          priority if (cur.hi_req <= mid) begin
            cur_next = '{node: left_node, lo_cov: cur.lo_cov, hi_cov: mid,
                         lo_req: cur.lo_req, hi_req: cur.hi_req, carry: ch_carry};
          end else if (cur.lo_req > mid) begin
            cur_next = '{node: right_node, lo_cov: mid_p1, hi_cov: cur.hi_cov,
                         lo_req: cur.lo_req, hi_req: cur.hi_req, carry: ch_carry};
          end else begin
            // range straddles the split: keep the right half for later
            push_en    = (sp < SP_W'(STACK_DEPTH));
            push_entry = '{node: right_node, lo_cov: mid_p1, hi_cov: cur.hi_cov,
                           lo_req: mid_p1, hi_req: cur.hi_req, carry: ch_carry};
            if (push_en) begin
              sp_next = sp + SP_W'(1);
            end
            cur_next = '{node: left_node, lo_cov: cur.lo_cov, hi_cov: mid,
                         lo_req: cur.lo_req, hi_req: mid, carry: ch_carry};
          end
        end
      end

      ST_ACC: begin
        total_next = total + sum_q + carry_q * 32'(span);
      end

      default: begin
        state_next = ST_CLEAR;
      end
    endcase

    // a fully covered node ends its branch: resume from the work list or finish
    if ((state == ST_ACC) || ((state == ST_EXEC) && exact && (op == OP_ADD))) begin
      if (sp != '0) begin
        cur_next   = stack[sp_m1[STK_AW-1:0]];
        sp_next    = sp_m1;
        state_next = ST_READ;
      end else begin
        done_next             = 1'b1;
        result_next.range_sum = (op == OP_QUERY) ? total_next : '0;
        result_next.bad_range = 1'b0;
        state_next            = ST_IDLE;
      end
    end else if ((state == ST_EXEC) && exact) begin
      state_next = ST_ACC;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr_addr   <= '0;
      leaf_count <= LEAF_COUNT_RST;
      sp         <= '0;
      done       <= 1'b0;
    end else begin
      state    <= state_next;
      clr_addr <= clr_addr_next;
      sp       <= sp_next;
      done     <= done_next;
      if (cfg_we) begin
        leaf_count <= cfg_wdata;
      end
    end
  end

  // walk and result payload
  always_ff @(posedge clk) begin
    cur     <= cur_next;
    op      <= op_next;
    amt     <= amt_next;
    total   <= total_next;
    prod    <= prod_next;
    node_ok <= node_ok_next;
    sum_q   <= sum_q_next;
    carry_q <= carry_q_next;
    result  <= result_next;
    if (push_en) begin
      stack[sp[STK_AW-1:0]] <= push_entry;
    end
  end

  // node sums
  rarst_ram #(
    .WIDTH (DATA_W),
    .DEPTH (TREE_NODES)
  ) u_sum_ram (
    .clk   (clk),
    .we    (sum_we),
    .waddr (wr_addr),
    .wdata (sum_wdata),
    .raddr (rd_addr),
    .rdata (sum_rdata)
  );

  // pending adds
  rarst_ram #(
    .WIDTH (DATA_W),
    .DEPTH (TREE_NODES)
  ) u_pend_ram (
    .clk   (clk),
    .we    (pend_we),
    .waddr (wr_addr),
    .wdata (pend_wdata),
    .raddr (rd_addr),
    .rdata (pend_rdata)
  );

endmodule

`default_nettype wire

FILE: sv/rarst_chk.sv
// port-level checker for the segment tree and its bind
`timescale 1ns / 1ps
`default_nettype none

module rarst_chk
  import rarst_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst,
  input wire logic      start,
  input wire logic      busy,
  input wire logic      done,
  input wire out_item_t result
);

  // the memory sweep keeps the block busy right after reset
  a_clear_after_reset: assert property (@(posedge clk) $fell(rst) |-> busy)
    else $error("block not busy after reset");

  // an accepted item either answers at once (bad range) or starts a walk
  a_accept_moves: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy || done)
    else $error("accepted item neither walking nor answered");

  // a rejected item reports a zero sum
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    done && result.bad_range |-> result.range_sum == '0)
    else $error("bad range with nonzero sum");

  // a good result only ends a walk
  a_good_after_walk: assert property (@(posedge clk) disable iff (rst)
    done && !result.bad_range |-> $past(busy))
    else $error("good result without a walk");

  // a bad range item came in on the cycle before its answer
  a_bad_after_start: assert property (@(posedge clk) disable iff (rst)
    done && result.bad_range |-> $past(start) && !$past(busy))
    else $error("bad range result without an item");

endmodule

bind range_add_range_sum_tree rarst_chk u_rarst_chk (.*);

`default_nettype wire
